// ----- rtl/dra_pkg.sv -----
// Shared types, constants and codes for the damage rectangle accumulator.
// Depends on nothing; every other file of the block imports it.
package dra_pkg;

	localparam int MAX_STORE  = 16;
	localparam int COORD_BITS = 16;
	localparam int MERGE_GAP  = 4;
	localparam int MAX_PASSES = 32;

	// Stored edges: left/top from a 16-bit input, right/bottom up to twice that.
	localparam int CW     = 18;
	localparam int DW     = CW - 1;
	localparam int DEPTH  = MAX_STORE + 1;
	localparam int AW     = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int PASS_W = $clog2(MAX_PASSES);
	localparam int EXT_MAX = (COORD_BITS >= 16) ? 65535 : ((1 << COORD_BITS) - 1);

	localparam logic [1:0] MODE_ADD   = 2'd0;
	localparam logic [1:0] MODE_CLEAR = 2'd1;
	localparam logic [1:0] MODE_DUMP  = 2'd2;

	localparam logic [2:0] WR_NEW      = 3'd0;
	localparam logic [2:0] WR_MERGE_R  = 3'd1;
	localparam logic [2:0] WR_MERGE_AB = 3'd2;
	localparam logic [2:0] WR_SHIFT    = 3'd3;
	localparam logic [2:0] WR_BOUNDS   = 3'd4;

	localparam logic [1:0] EM_ZERO   = 2'd0;
	localparam logic [1:0] EM_BOUNDS = 2'd1;
	localparam logic [1:0] EM_READ   = 2'd2;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [15:0] rect_x;
		logic signed [15:0] rect_y;
		logic signed [15:0] rect_w;
		logic signed [15:0] rect_h;
	} req_t;

	typedef struct packed {
		logic signed [15:0] out_x;
		logic signed [15:0] out_y;
		logic [15:0]        out_w;
		logic [15:0]        out_h;
		logic [4:0]         rect_count;
		logic               last;
	} rsp_t;

	typedef struct packed {
		logic signed [CW-1:0] x0;
		logic signed [CW-1:0] y0;
		logic signed [CW-1:0] x1;
		logic signed [CW-1:0] y1;
	} box_t;

	typedef struct packed {
		logic             load;
		logic             rd_en;
		logic [AW-1:0]    rd_a;
		logic [AW-1:0]    rd_b;
		logic             wr_en;
		logic [AW-1:0]    wr_addr;
		logic [2:0]       wr_sel;
		logic             bnd_add;
		logic             bnd_first;
		logic             emit;
		logic [1:0]       emit_sel;
		logic             emit_last;
		logic [CNT_W-1:0] count;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic merge_ok;
		logic near_ab;
	} sts_t;

endpackage

// ----- rtl/damage_rect_accumulator.sv -----
// Damage rectangle accumulator: keeps up to 16 damaged screen rectangles and merges neighbors.
// Requests are taken one at a time; a request is accepted only while the controller is
// idle, but the result register lets a new request in while the previous result waits.
// The work is sequenced by the controller stepping through the single rectangle store with a
// registered read: clear and an ignored add go straight to their result; an add reads,
// checks and compares each stored rectangle in turn and appends if none merges; dump
// reads and emits one stored rectangle at a time. When an append pushes the count above
// the configured limit, consolidation checks one pair of stored rectangles at a time,
// and each merge moves the later entries down one entry at a time, for at most 32 merge
// passes; a final collapse to one bounding box follows if the count stays over the limit.
// Depends on dra_pkg, dra_ctrl and dra_datapath.
module damage_rect_accumulator (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  dra_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output dra_pkg::rsp_t rsp,
	input  logic          cfg_wen,
	input  logic [4:0]    cfg_wdata
);
	import dra_pkg::*;

	// The controller owns the list count and all loop indexes; the datapath owns the
	// rectangle store, the overall bounds and the area test.
	cmd_t cmd;
	sts_t sts;

	dra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts)
	);

	dra_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// ----- rtl/dra_datapath.sv -----
// Datapath: rectangle store, read registers, area test, bounds and result register.
// Depends on dra_pkg; driven by dra_ctrl through cmd_t and answers with sts_t.
module dra_datapath (
	input  logic          clk,
	input  logic          arst_n,
	input  dra_pkg::req_t req,
	input  dra_pkg::cmd_t cmd,
	output dra_pkg::sts_t sts,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output dra_pkg::rsp_t rsp
);
	import dra_pkg::*;

	localparam int AR = 2 * DW;
	localparam logic signed [CW:0] GAP = (CW+1)'(MERGE_GAP);

	function automatic logic signed [CW:0] sx(input logic signed [CW-1:0] v);
		return {v[CW-1], v};
	endfunction

	function automatic logic box_near(input box_t a, input box_t b);
		return (sx(a.x0) - GAP < sx(b.x1)) && (sx(a.x1) + GAP > sx(b.x0)) &&
			(sx(a.y0) - GAP < sx(b.y1)) && (sx(a.y1) + GAP > sx(b.y0));
	endfunction

	function automatic box_t box_join(input box_t a, input box_t b);
		box_t r;
		r.x0 = (a.x0 < b.x0) ? a.x0 : b.x0;
		r.y0 = (a.y0 < b.y0) ? a.y0 : b.y0;
		r.x1 = (a.x1 > b.x1) ? a.x1 : b.x1;
		r.y1 = (a.y1 > b.y1) ? a.y1 : b.y1;
		return r;
	endfunction

	function automatic logic [DW-1:0] span(input logic signed [CW-1:0] lo,
		input logic signed [CW-1:0] hi);
		logic [CW-1:0] d;
		d = hi - lo;
		return d[DW-1:0];
	endfunction

	function automatic logic [15:0] sat(input logic [DW-1:0] d);
		return (d > DW'(EXT_MAX)) ? 16'(EXT_MAX) : d[15:0];
	endfunction

	box_t mem [DEPTH];
	box_t r_q, ra_q, rb_q, bnd_q;
	box_t new_box, wdata, em_box, join_r;
	logic [AR-1:0] an_q, am_q, as_q;
	logic near_q;
	logic [AR+2:0] lhs, rhs;
	logic [AR:0] area_sum;
	rsp_t rsp_q;
	logic valid_q;

	always_comb begin
		new_box.x0 = {{(CW-16){req.rect_x[15]}}, req.rect_x};
		new_box.y0 = {{(CW-16){req.rect_y[15]}}, req.rect_y};
		new_box.x1 = new_box.x0 + {{(CW-16){req.rect_w[15]}}, req.rect_w};
		new_box.y1 = new_box.y0 + {{(CW-16){req.rect_h[15]}}, req.rect_h};
	end

	assign join_r = box_join(ra_q, r_q);

	always_comb begin
		case (cmd.wr_sel)
			WR_NEW:      wdata = r_q;
			WR_MERGE_R:  wdata = join_r;
			WR_MERGE_AB: wdata = box_join(ra_q, rb_q);
			WR_SHIFT:    wdata = ra_q;
			WR_BOUNDS:   wdata = bnd_q;
			default:     wdata = r_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			r_q <= new_box;
		end
		if (cmd.rd_en) begin
			ra_q <= mem[cmd.rd_a];
			rb_q <= mem[cmd.rd_b];
		end
		if (cmd.wr_en) begin
			mem[cmd.wr_addr] <= wdata;
		end
		if (cmd.bnd_add) begin
			bnd_q <= cmd.bnd_first ? r_q : box_join(bnd_q, r_q);
		end
		// Area terms of the scan candidate, one multiplier per term.
		am_q   <= span(join_r.x0, join_r.x1) * span(join_r.y0, join_r.y1);
		as_q   <= span(ra_q.x0, ra_q.x1) * span(ra_q.y0, ra_q.y1);
		an_q   <= span(r_q.x0, r_q.x1) * span(r_q.y0, r_q.y1);
		near_q <= box_near(ra_q, r_q);
	end

	// Merge when the boxes are near and twice the joined area stays within three times the sum of both areas.
	always_comb begin
		area_sum = (AR+1)'(as_q) + (AR+1)'(an_q);
		lhs      = (AR+3)'({am_q, 1'b0});
		rhs      = (AR+3)'(area_sum) + (AR+3)'({area_sum, 1'b0});
	end

	assign sts.merge_ok = near_q && (lhs <= rhs);
	assign sts.near_ab  = box_near(ra_q, rb_q);
	assign sts.out_free = !valid_q || rsp_ready;

	assign em_box = (cmd.emit_sel == EM_READ) ? ra_q : bnd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.emit) begin
			valid_q <= 1'b1;
		end else if (rsp_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (cmd.emit_sel == EM_ZERO) begin
				rsp_q.out_x <= '0;
				rsp_q.out_y <= '0;
				rsp_q.out_w <= '0;
				rsp_q.out_h <= '0;
			end else begin
				rsp_q.out_x <= em_box.x0[15:0];
				rsp_q.out_y <= em_box.y0[15:0];
				rsp_q.out_w <= sat(span(em_box.x0, em_box.x1));
				rsp_q.out_h <= sat(span(em_box.y0, em_box.y1));
			end
			rsp_q.rect_count <= 5'(cmd.count);
			rsp_q.last       <= cmd.emit_last;
		end
	end

	assign rsp_valid = valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- rtl/dra_ctrl.sv -----
// Controller: sequences add, scan, consolidation, collapse, clear and dump.
// Depends on dra_pkg; steers dra_datapath through cmd_t and reads sts_t.
module dra_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  dra_pkg::req_t req,
	input  logic          cfg_wen,
	input  logic [4:0]    cfg_wdata,
	output dra_pkg::cmd_t cmd,
	input  dra_pkg::sts_t sts
);
	import dra_pkg::*;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_EMIT    = 4'd1;
	localparam logic [3:0] S_SC_RD   = 4'd2;
	localparam logic [3:0] S_SC_CHK  = 4'd3;
	localparam logic [3:0] S_SC_CMP  = 4'd4;
	localparam logic [3:0] S_APPEND  = 4'd5;
	localparam logic [3:0] S_CN_RD   = 4'd6;
	localparam logic [3:0] S_CN_CHK  = 4'd7;
	localparam logic [3:0] S_SH_RD   = 4'd8;
	localparam logic [3:0] S_SH_WR   = 4'd9;
	localparam logic [3:0] S_CN_NEXT = 4'd10;
	localparam logic [3:0] S_DONE    = 4'd11;
	localparam logic [3:0] S_DP_RD   = 4'd12;
	localparam logic [3:0] S_DP_EMIT = 4'd13;

	localparam logic [PASS_W-1:0] PASS_LAST = PASS_W'(MAX_PASSES - 1);

	logic [3:0] state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d, limit, cnt_inc;
	logic [4:0] max_q;
	logic [AW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
	logic [PASS_W-1:0] pass_q, pass_d;
	logic rect_ok;

	assign rect_ok = (req.rect_w > 16'sd0) && (req.rect_h > 16'sd0);
	assign limit   = (CNT_W'(max_q) > CNT_W'(MAX_STORE)) ? CNT_W'(MAX_STORE) : CNT_W'(max_q);
	assign cnt_inc = count_q + CNT_W'(1);

	always_comb begin
		cmd       = '0;
		cmd.count = count_q;
		state_d   = state_q;
		count_d   = count_q;
		i_d       = i_q;
		j_d       = j_q;
		k_d       = k_q;
		pass_d    = pass_q;
		req_ready = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					case (req.mode)
						MODE_CLEAR: begin
							count_d = '0;
							state_d = S_EMIT;
						end
						MODE_DUMP: begin
							if (count_q == '0) begin
								state_d = S_EMIT;
							end else begin
								k_d     = '0;
								state_d = S_DP_RD;
							end
						end
						MODE_ADD: begin
							if (!rect_ok) begin
								state_d = S_EMIT;
							end else if (count_q == '0) begin
								state_d = S_APPEND;
							end else begin
								i_d     = '0;
								state_d = S_SC_RD;
							end
						end
						default: state_d = S_EMIT;
					endcase
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_sel  = (count_q == '0) ? EM_ZERO : EM_BOUNDS;
					cmd.emit_last = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_SC_RD: begin
				cmd.rd_en = 1'b1;
				cmd.rd_a  = i_q;
				state_d   = S_SC_CHK;
			end
			S_SC_CHK: state_d = S_SC_CMP;
			S_SC_CMP: begin
				if (sts.merge_ok) begin
					cmd.wr_en   = 1'b1;
					cmd.wr_addr = i_q;
					cmd.wr_sel  = WR_MERGE_R;
					cmd.bnd_add = 1'b1;
					state_d     = S_EMIT;
				end else if (CNT_W'(i_q) + CNT_W'(1) == count_q) begin
					state_d = S_APPEND;
				end else begin
					i_d     = i_q + AW'(1);
					state_d = S_SC_RD;
				end
			end
			S_APPEND: begin
				cmd.wr_en     = 1'b1;
				cmd.wr_addr   = AW'(count_q);
				cmd.wr_sel    = WR_NEW;
				cmd.bnd_add   = 1'b1;
				cmd.bnd_first = (count_q == '0);
				count_d       = cnt_inc;
				if (cnt_inc > limit && cnt_inc >= CNT_W'(2)) begin
					pass_d  = '0;
					i_d     = '0;
					j_d     = AW'(1);
					state_d = S_CN_RD;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_CN_RD: begin
				cmd.rd_en = 1'b1;
				cmd.rd_a  = i_q;
				cmd.rd_b  = j_q;
				state_d   = S_CN_CHK;
			end
			S_CN_CHK: begin
				if (sts.near_ab) begin
					cmd.wr_en   = 1'b1;
					cmd.wr_addr = i_q;
					cmd.wr_sel  = WR_MERGE_AB;
					if (CNT_W'(j_q) + CNT_W'(1) < count_q) begin
						k_d     = j_q;
						state_d = S_SH_RD;
					end else begin
						count_d = count_q - CNT_W'(1);
						state_d = S_CN_NEXT;
					end
				end else if (CNT_W'(j_q) + CNT_W'(1) < count_q) begin
					j_d     = j_q + AW'(1);
					state_d = S_CN_RD;
				end else if (CNT_W'(i_q) + CNT_W'(2) < count_q) begin
					i_d     = i_q + AW'(1);
					j_d     = i_q + AW'(2);
					state_d = S_CN_RD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SH_RD: begin
				cmd.rd_en = 1'b1;
				cmd.rd_a  = k_q + AW'(1);
				state_d   = S_SH_WR;
			end
			S_SH_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_addr = k_q;
				cmd.wr_sel  = WR_SHIFT;
				if (CNT_W'(k_q) + CNT_W'(2) < count_q) begin
					k_d     = k_q + AW'(1);
					state_d = S_SH_RD;
				end else begin
					count_d = count_q - CNT_W'(1);
					state_d = S_CN_NEXT;
				end
			end
			S_CN_NEXT: begin
				if (pass_q == PASS_LAST || count_q < CNT_W'(2)) begin
					state_d = S_DONE;
				end else begin
					pass_d  = pass_q + PASS_W'(1);
					i_d     = '0;
					j_d     = AW'(1);
					state_d = S_CN_RD;
				end
			end
			S_DONE: begin
				if (count_q > limit) begin
					cmd.wr_en   = 1'b1;
					cmd.wr_addr = '0;
					cmd.wr_sel  = WR_BOUNDS;
					count_d     = CNT_W'(1);
				end
				state_d = S_EMIT;
			end
			S_DP_RD: begin
				cmd.rd_en = 1'b1;
				cmd.rd_a  = k_q;
				state_d   = S_DP_EMIT;
			end
			S_DP_EMIT: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_sel  = EM_READ;
					cmd.emit_last = (CNT_W'(k_q) + CNT_W'(1) == count_q);
					if (cmd.emit_last) begin
						state_d = S_IDLE;
					end else begin
						k_d     = k_q + AW'(1);
						state_d = S_DP_RD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			max_q   <= 5'(MAX_STORE);
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			pass_q  <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			i_q     <= i_d;
			j_q     <= j_d;
			k_q     <= k_d;
			pass_q  <= pass_d;
			if (cfg_wen) begin
				max_q <= cfg_wdata;
			end
		end
	end

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (count_q <= CNT_W'(MAX_STORE)))
		else $error("list holds more rectangles than the store allows");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result issued while result register is occupied");

	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> (CNT_W'(cmd.wr_addr) <= CNT_W'(MAX_STORE)))
		else $error("store write beyond last entry");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q != S_IDLE))
		else $error("accepted request left controller idle");

endmodule

// ----- test/damage_rect_accumulator_tb.sv -----
// Self-checking testbench for damage_rect_accumulator: drives add, clear, dump and spare-mode requests
// and compares every response against an in-bench rectangle list predictor.
// Depends on dra_pkg and the damage_rect_accumulator RTL.
`timescale 1ns / 1ps

module damage_rect_accumulator_tb;
	import dra_pkg::*;

	// Mode code with no operation of its own; the block answers it like an ignored add.
	localparam logic [1:0] MODE_SPARE = 2'd3;

	// Wide edges so that right/bottom sums never wrap.
	typedef struct {
		int x0, y0, x1, y1;
	} edge_box_t;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;
	logic cfg_wen;
	logic [4:0] cfg_wdata;

	damage_rect_accumulator DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
	);

	// Predictor state: the rectangle list, its length and the limit register.
	edge_box_t damage_list[MAX_STORE + 1];
	int damage_count;
	int limit_reg;

	req_t pending_requests[$];
	rsp_t expected_responses[$];
	int errors;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_off_cycles;
	// Requests presented by the driver and requests taken by the block.
	int offered_total = 0;
	int accepted_total = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void queue_request(req_t q);
		pending_requests = {pending_requests, q};
	endfunction

	function automatic void expect_response(rsp_t r);
		expected_responses = {expected_responses, r};
	endfunction

	function automatic bit near_boxes(edge_box_t a, edge_box_t b);
		return a.x0 - MERGE_GAP < b.x1 && a.x1 + MERGE_GAP > b.x0 &&
			a.y0 - MERGE_GAP < b.y1 && a.y1 + MERGE_GAP > b.y0;
	endfunction

	function automatic edge_box_t join_boxes(edge_box_t a, edge_box_t b);
		edge_box_t r;
		r.x0 = a.x0 < b.x0 ? a.x0 : b.x0;
		r.y0 = a.y0 < b.y0 ? a.y0 : b.y0;
		r.x1 = a.x1 > b.x1 ? a.x1 : b.x1;
		r.y1 = a.y1 > b.y1 ? a.y1 : b.y1;
		return r;
	endfunction

	function automatic longint box_area(edge_box_t a);
		return longint'(a.x1 - a.x0) * longint'(a.y1 - a.y0);
	endfunction

	function automatic edge_box_t list_bounds();
		edge_box_t r;
		r = damage_list[0];
		for (int i = 1; i < damage_count; i++)
			r = join_boxes(r, damage_list[i]);
		return r;
	endfunction

	function automatic int active_limit();
		return limit_reg > MAX_STORE ? MAX_STORE : limit_reg;
	endfunction

	function automatic logic [15:0] clamp_extent(int d);
		if (d <= 0)
			return 16'd0;
		return d > EXT_MAX ? 16'(EXT_MAX) : 16'(d);
	endfunction

	function automatic rsp_t box_response(edge_box_t b, bit is_empty, bit last);
		rsp_t r;
		r = '0;
		if (!is_empty) begin
			r.out_x = 16'(b.x0);
			r.out_y = 16'(b.y0);
			r.out_w = clamp_extent(b.x1 - b.x0);
			r.out_h = clamp_extent(b.y1 - b.y0);
		end
		r.rect_count = 5'(damage_count);
		r.last = last;
		return r;
	endfunction

	// Pairwise merging without the area test, then a collapse if still over the limit.
	task automatic consolidate_list();
		int passes;
		bit merged;
		passes = 0;
		if (damage_count < 2)
			return;
		do begin
			merged = 0;
			for (int i = 0; i < damage_count && !merged; i++) begin
				for (int j = i + 1; j < damage_count; j++) begin
					if (near_boxes(damage_list[i], damage_list[j])) begin
						damage_list[i] = join_boxes(damage_list[i], damage_list[j]);
						for (int k = j; k + 1 < damage_count; k++)
							damage_list[k] = damage_list[k + 1];
						damage_count--;
						merged = 1;
						break;
					end
				end
			end
			passes++;
		end while (merged && passes < MAX_PASSES);
		if (damage_count > active_limit()) begin
			damage_list[0] = list_bounds();
			damage_count = 1;
		end
	endtask

	task automatic add_damage(edge_box_t r);
		edge_box_t m;
		for (int i = 0; i < damage_count; i++) begin
			if (near_boxes(damage_list[i], r)) begin
				m = join_boxes(damage_list[i], r);
				if (2 * box_area(m) <= 3 * (box_area(damage_list[i]) + box_area(r))) begin
					damage_list[i] = m;
					return;
				end
			end
		end
		if (damage_count <= MAX_STORE) begin
			damage_list[damage_count] = r;
			damage_count++;
		end
		if (damage_count > active_limit())
			consolidate_list();
	endtask

	// Applies one request to the predictor and queues the responses it causes.
	task automatic predict_responses(req_t q);
		edge_box_t r;
		int n;
		if (q.mode == MODE_CLEAR) begin
			damage_count = 0;
			expect_response(box_response(r, 1, 1));
			return;
		end
		if (q.mode == MODE_DUMP) begin
			if (damage_count == 0) begin
				expect_response(box_response(r, 1, 1));
				return;
			end
			n = damage_count < MAX_STORE ? damage_count : MAX_STORE;
			for (int i = 0; i < n; i++)
				expect_response(box_response(damage_list[i], 0, i + 1 == n));
			return;
		end
		if (q.mode == MODE_ADD && q.rect_w > 0 && q.rect_h > 0) begin
			r.x0 = q.rect_x;
			r.y0 = q.rect_y;
			r.x1 = int'(q.rect_x) + int'(q.rect_w);
			r.y1 = int'(q.rect_y) + int'(q.rect_h);
			add_damage(r);
		end
		if (damage_count == 0)
			expect_response(box_response(r, 1, 1));
		else
			expect_response(box_response(list_bounds(), 0, 1));
	endtask

	// Driver: presents the queue head on the falling edge and keeps it until taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (req_valid && accepted_total != offered_total) begin
			req_valid <= 1'b1;
		end else if (pending_requests.size() > 0 &&
				$urandom_range(99) >= send_idle_pct) begin
			req <= pending_requests.pop_front();
			req_valid <= 1'b1;
			offered_total <= offered_total + 1;
		end else begin
			req_valid <= 1'b0;
		end
	end

	// The prediction is made at acceptance, so it follows the order the block sees.
	always @(posedge clk) begin
		if (arst_n && req_valid && req_ready) begin
			predict_responses(req);
			accepted_total <= accepted_total + 1;
		end
	end

	// Receiver: randomly stalls, and honors a counted hold-off when one is requested.
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else if (hold_off_cycles > 0) begin
			rsp_ready <= 1'b0;
			hold_off_cycles <= hold_off_cycles - 1;
		end else begin
			rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor: each accepted response is checked against the oldest expectation.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_responses.size() == 0) begin
				$display("%0t ERROR: unexpected response %p", $time, rsp);
				errors++;
			end else begin
				want = expected_responses.pop_front();
				if (rsp.out_x !== want.out_x || rsp.out_y !== want.out_y ||
						rsp.out_w !== want.out_w || rsp.out_h !== want.out_h ||
						rsp.rect_count !== want.rect_count || rsp.last !== want.last) begin
					$display("%0t ERROR: expected %p actual %p", $time, want, rsp);
					errors++;
				end
			end
		end
	end

	function automatic req_t make_request(logic [1:0] mode, int x, int y, int w, int h);
		req_t q;
		q.mode = mode;
		q.rect_x = 16'(x);
		q.rect_y = 16'(y);
		q.rect_w = 16'(w);
		q.rect_h = 16'(h);
		return q;
	endfunction

	// Mostly small rectangles clustered in a region so merges happen; some wild ones.
	function automatic req_t random_request();
		int pick;
		pick = $urandom_range(99);
		if (pick < 6)
			return make_request(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom);
		if (pick < 14)
			return make_request(MODE_DUMP, $urandom, $urandom, $urandom, $urandom);
		if (pick < 17)
			return make_request(MODE_SPARE, $urandom, $urandom, $urandom, $urandom);
		if (pick < 27)
			return make_request(MODE_ADD, $urandom, $urandom, $urandom, $urandom);
		return make_request(MODE_ADD, $urandom_range(200) - 100, $urandom_range(200) - 100,
			$urandom_range(40) - 2, $urandom_range(40) - 2);
	endfunction

	task automatic wait_drained();
		while (pending_requests.size() > 0 || req_valid || expected_responses.size() > 0)
			@(posedge clk);
		// Let the block settle before the next phase.
		repeat (20) @(posedge clk);
	endtask

	task automatic write_limit(int value);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= 5'(value);
		limit_reg = value;
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic run_random(int count);
		for (int i = 0; i < count; i++)
			queue_request(random_request());
		wait_drained();
	endtask

	initial begin
		errors = 0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_cycles = 0;
		damage_count = 0;
		limit_reg = 16;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty list, every mode, extreme fields, ignored adds, saturation.
		queue_request(make_request(MODE_DUMP, 0, 0, 0, 0));
		queue_request(make_request(MODE_ADD, 0, 0, 0, 5));
		queue_request(make_request(MODE_ADD, 0, 0, 5, -32768));
		queue_request(make_request(MODE_SPARE, 1, 2, 3, 4));
		queue_request(make_request(MODE_ADD, -32768, -32768, 32767, 32767));
		queue_request(make_request(MODE_ADD, 32767, 32767, 32767, 32767));
		queue_request(make_request(MODE_DUMP, 0, 0, 0, 0));
		queue_request(make_request(MODE_CLEAR, -1, -1, -1, -1));
		queue_request(make_request(MODE_ADD, 0, 0, 10, 10));
		queue_request(make_request(MODE_ADD, 13, 0, 10, 10));
		queue_request(make_request(MODE_ADD, 100, 100, 1, 1));
		queue_request(make_request(MODE_ADD, 0, 50, 1, 1));
		queue_request(make_request(MODE_DUMP, 0, 0, 0, 0));
		queue_request(make_request(MODE_CLEAR, 0, 0, 0, 0));
		wait_drained();

		// Limit of 1 forces consolidation and collapse on nearly every append.
		write_limit(1);
		for (int i = 0; i < 4; i++)
			queue_request(make_request(MODE_ADD, i * 50, i * 50, 3, 3));
		queue_request(make_request(MODE_DUMP, 0, 0, 0, 0));
		wait_drained();

		// Out-of-range limits: zero and above the store size.
		write_limit(0);
		queue_request(make_request(MODE_ADD, 500, 500, 2, 2));
		queue_request(make_request(MODE_DUMP, 0, 0, 0, 0));
		wait_drained();
		write_limit(31);
		queue_request(make_request(MODE_CLEAR, 0, 0, 0, 0));
		for (int i = 0; i < 18; i++)
			queue_request(make_request(MODE_ADD, i * 1000, 0, 5, 5));
		queue_request(make_request(MODE_DUMP, 0, 0, 0, 0));
		wait_drained();

		// Random phases with different idling and limits.
		write_limit(16);
		run_random(12);
		send_idle_pct = 53;
		write_limit(4);
		run_random(12);
		send_idle_pct = 0;
		recv_stall_pct = 53;
		write_limit(2);
		run_random(12);
		send_idle_pct = 16;
		recv_stall_pct = 16;
		write_limit(9);
		run_random(12);

		// Long receiver hold-off while the sender keeps offering, so input backs up.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_cycles = 400;
		for (int i = 0; i < 10; i++)
			queue_request(make_request(MODE_DUMP, 0, 0, 0, 0));
		wait_drained();

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#200ms;
		$display("FAIL");
		$finish;
	end

endmodule
